// ----- hw/rtl/grid_cell_from_parallelogram_unit_defines.svh -----
// Assertion macros shared by the grid cell unit RTL
`ifndef GRID_CELL_FROM_PARALLELOGRAM_UNIT_DEFINES_SVH
`define GRID_CELL_FROM_PARALLELOGRAM_UNIT_DEFINES_SVH

// same-cycle implication
`define GCP_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define GCP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hw/rtl/gcp_pkg.sv -----
// Package: constants, register map and helpers of the grid cell unit
package gcp_pkg;

   localparam int COORD_BITS_DEF = 12;
   localparam int ID_BITS_DEF    = 8;

   // corner registers
   localparam int NUM_REGS      = 6;
   localparam int REG_IDX_BITS  = $clog2(NUM_REGS);
   localparam int CSR_ADDR_BITS = $clog2(NUM_REGS * 4);
   localparam int CSR_DATA_BITS = 32;

   localparam logic [REG_IDX_BITS-1:0] REG_TOP_LEFT_X    = REG_IDX_BITS'(0);
   localparam logic [REG_IDX_BITS-1:0] REG_TOP_LEFT_Y    = REG_IDX_BITS'(1);
   localparam logic [REG_IDX_BITS-1:0] REG_TOP_RIGHT_X   = REG_IDX_BITS'(2);
   localparam logic [REG_IDX_BITS-1:0] REG_TOP_RIGHT_Y   = REG_IDX_BITS'(3);
   localparam logic [REG_IDX_BITS-1:0] REG_BOTTOM_LEFT_X = REG_IDX_BITS'(4);
   localparam logic [REG_IDX_BITS-1:0] REG_BOTTOM_LEFT_Y = REG_IDX_BITS'(5);

   // pipeline: diff, multiply, combine, normalize, compare
   localparam int NUM_STAGES = 5;

   // grid cell codes
   localparam logic [1:0] CELL_LO  = 2'd0;
   localparam logic [1:0] CELL_MID = 2'd1;
   localparam logic [1:0] CELL_HI  = 2'd2;

   // below_lo: 4n < det, below_hi: 4n < 3*det
   function automatic logic [1:0] cell_of(input logic below_lo, input logic below_hi);
      logic [1:0] code;
      if (below_lo) begin
         code = CELL_LO;
      end else if (below_hi) begin
         code = CELL_MID;
      end else begin
         code = CELL_HI;
      end
      return code;
   endfunction

endpackage

// ----- hw/rtl/grid_cell_from_parallelogram_unit.sv -----
// Accepted points reach the rsp side through five register stages (diff,
// multiply, combine, normalize, compare), each holding one item, which
// stall stage by stage. Throughput: one point per cycle while not stalled.
// A held result stalls only the stages behind it; empty stages keep filling.
// Reset (synchronous, active high) clears the stage valid bits and the
// six corner registers to 0.
`include "grid_cell_from_parallelogram_unit_defines.svh"

module grid_cell_from_parallelogram_unit import gcp_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEF,
   parameter int ID_BITS    = ID_BITS_DEF,
   localparam int REQ_BITS  = ((2 * COORD_BITS + ID_BITS + 7) / 8) * 8,
   localparam int RSP_BITS  = ((ID_BITS + 4 + 7) / 8) * 8
) (
   input  logic                     clock,
   input  logic                     reset,
   // input items
   input  logic                     req_tvalid,
   output logic                     req_tready,
   // point_x, point_y, point_id (lowest bit first), zero padded
   input  logic [REQ_BITS-1:0]      req_tdata,
   // result items
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   // result_id, grid_row, grid_col (lowest bit first), zero padded
   output logic [RSP_BITS-1:0]      rsp_tdata,
   // degenerate
   output logic                     rsp_tuser,
   // configuration
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                     csr_pready
);

   localparam int SUM_BITS = 2 * COORD_BITS + 3;

   logic [COORD_BITS-1:0]      corner [NUM_REGS];
   logic [COORD_BITS-1:0]      point_x, point_y;
   logic [ID_BITS-1:0]         point_id;

   logic [NUM_STAGES-1:0]      valid_ff, valid_in;
   logic [NUM_STAGES-1:0]      stage_en;
   logic [ID_BITS-1:0]         id_ff [NUM_STAGES];

   logic signed [SUM_BITS-1:0] det, nu, nv;
   logic [1:0]                 grid_row, grid_col;
   logic                       degenerate;

   assign point_x  = req_tdata[COORD_BITS-1:0];
   assign point_y  = req_tdata[2*COORD_BITS-1:COORD_BITS];
   assign point_id = req_tdata[2*COORD_BITS+ID_BITS-1:2*COORD_BITS];

   // A stage loads when it is empty or its contents move on.
   always_comb begin
      stage_en[NUM_STAGES-1] = !valid_ff[NUM_STAGES-1] || rsp_tready;
      for (int k = NUM_STAGES - 2; k >= 0; k--) begin
         stage_en[k] = !valid_ff[k] || stage_en[k+1];
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (stage_en[0]) begin
         valid_in[0] = req_tvalid;
      end
      for (int k = 1; k < NUM_STAGES; k++) begin
         if (stage_en[k]) begin
            valid_in[k] = valid_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // id travels alongside the arithmetic
   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         id_ff[0] <= point_id;
      end
      for (int k = 1; k < NUM_STAGES; k++) begin
         if (stage_en[k]) begin
            id_ff[k] <= id_ff[k-1];
         end
      end
   end

   gcp_csr #(.COORD_BITS(COORD_BITS)) u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .corner      (corner)
   );

   gcp_mul #(.COORD_BITS(COORD_BITS)) u_mul (
      .clock    (clock),
      .stage_en (stage_en[2:0]),
      .point_x  (point_x),
      .point_y  (point_y),
      .corner   (corner),
      .det      (det),
      .nu       (nu),
      .nv       (nv)
   );

   gcp_cell #(.COORD_BITS(COORD_BITS)) u_cell (
      .clock      (clock),
      .stage_en   (stage_en[4:3]),
      .det        (det),
      .nu         (nu),
      .nv         (nv),
      .grid_row   (grid_row),
      .grid_col   (grid_col),
      .degenerate (degenerate)
   );

   assign req_tready = stage_en[0];
   assign rsp_tvalid = valid_ff[NUM_STAGES-1];
   assign rsp_tdata  = RSP_BITS'({grid_col, grid_row, id_ff[NUM_STAGES-1]});
   assign rsp_tuser  = degenerate;

   `GCP_ASSERT_IMPLY(a_degen_cell_zero, clock, reset,
      rsp_tvalid && degenerate, grid_row == CELL_LO && grid_col == CELL_LO,
      "degenerate result with nonzero cell")
   `GCP_ASSERT_NEXT(a_accept_enters, clock, reset,
      req_tvalid && req_tready, valid_ff[0],
      "accepted item did not enter the first stage")
   `GCP_ASSERT_NEXT(a_stall_holds, clock, reset,
      !stage_en[0], valid_ff[0],
      "stalled first stage lost its item")
   `GCP_ASSERT_IMPLY(a_cell_range, clock, reset,
      rsp_tvalid, grid_row != 2'd3 && grid_col != 2'd3,
      "cell index out of range")

endmodule

// ----- hw/rtl/gcp_csr.sv -----
// Corner register file behind the APB-style port
module gcp_csr import gcp_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                     csr_pready,
   output logic [COORD_BITS-1:0]    corner [NUM_REGS]
);

   logic [COORD_BITS-1:0]   corner_ff [NUM_REGS];
   logic [COORD_BITS-1:0]   corner_in [NUM_REGS];
   logic [REG_IDX_BITS-1:0] reg_idx;
   logic                    wr_en;

   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[CSR_ADDR_BITS-1:2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      for (int i = 0; i < NUM_REGS; i++) begin
         corner_in[i] = (wr_en && reg_idx == REG_IDX_BITS'(i)) ?
                        csr_pwdata[COORD_BITS-1:0] : corner_ff[i];
      end
   end

   always_comb begin
      csr_prdata = '0;
      for (int i = 0; i < NUM_REGS; i++) begin
         if (reg_idx == REG_IDX_BITS'(i)) begin
            csr_prdata = CSR_DATA_BITS'(corner_ff[i]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_REGS; i++) begin
            corner_ff[i] <= '0;
         end
      end else begin
         for (int i = 0; i < NUM_REGS; i++) begin
            corner_ff[i] <= corner_in[i];
         end
      end
   end

   assign corner = corner_ff;

endmodule

// ----- hw/rtl/gcp_mul.sv -----
// Front stages: edge and offset vectors, products, determinant and numerators
module gcp_mul import gcp_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEF,
   localparam int SUM_BITS  = 2 * COORD_BITS + 3
) (
   input  logic                       clock,
   input  logic [2:0]                 stage_en,
   input  logic [COORD_BITS-1:0]      point_x,
   input  logic [COORD_BITS-1:0]      point_y,
   input  logic [COORD_BITS-1:0]      corner [NUM_REGS],
   output logic signed [SUM_BITS-1:0] det,
   output logic signed [SUM_BITS-1:0] nu,
   output logic signed [SUM_BITS-1:0] nv
);

   localparam int DIFF_BITS = COORD_BITS + 1;
   localparam int PROD_BITS = 2 * COORD_BITS + 2;

   function automatic logic signed [DIFF_BITS-1:0] sub_u(input logic [COORD_BITS-1:0] x,
                                                         input logic [COORD_BITS-1:0] y);
      return $signed({1'b0, x}) - $signed({1'b0, y});
   endfunction

   // stage 1: differences
   logic signed [DIFF_BITS-1:0] a_ff, b_ff, c_ff, d_ff, rx_ff, ry_ff;
   // stage 2: products
   logic signed [PROD_BITS-1:0] ad_ff, bc_ff, drx_ff, bry_ff, ary_ff, crx_ff;
   // stage 3: sums
   logic signed [SUM_BITS-1:0]  det_ff, nu_ff, nv_ff;

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         a_ff  <= sub_u(corner[REG_TOP_RIGHT_X],   corner[REG_TOP_LEFT_X]);
         c_ff  <= sub_u(corner[REG_TOP_RIGHT_Y],   corner[REG_TOP_LEFT_Y]);
         b_ff  <= sub_u(corner[REG_BOTTOM_LEFT_X], corner[REG_TOP_LEFT_X]);
         d_ff  <= sub_u(corner[REG_BOTTOM_LEFT_Y], corner[REG_TOP_LEFT_Y]);
         rx_ff <= sub_u(point_x, corner[REG_TOP_LEFT_X]);
         ry_ff <= sub_u(point_y, corner[REG_TOP_LEFT_Y]);
      end
      if (stage_en[1]) begin
         ad_ff  <= a_ff * d_ff;
         bc_ff  <= b_ff * c_ff;
         drx_ff <= d_ff * rx_ff;
         bry_ff <= b_ff * ry_ff;
         ary_ff <= a_ff * ry_ff;
         crx_ff <= c_ff * rx_ff;
      end
      if (stage_en[2]) begin
         det_ff <= SUM_BITS'(ad_ff)  - SUM_BITS'(bc_ff);
         nu_ff  <= SUM_BITS'(drx_ff) - SUM_BITS'(bry_ff);
         nv_ff  <= SUM_BITS'(ary_ff) - SUM_BITS'(crx_ff);
      end
   end

   assign det = det_ff;
   assign nu  = nu_ff;
   assign nv  = nv_ff;

endmodule

// ----- hw/rtl/gcp_cell.sv -----
// Back stages: sign normalization, scaling and cell comparison
module gcp_cell import gcp_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEF,
   localparam int SUM_BITS  = 2 * COORD_BITS + 3
) (
   input  logic                       clock,
   input  logic [1:0]                 stage_en,
   input  logic signed [SUM_BITS-1:0] det,
   input  logic signed [SUM_BITS-1:0] nu,
   input  logic signed [SUM_BITS-1:0] nv,
   output logic [1:0]                 grid_row,
   output logic [1:0]                 grid_col,
   output logic                       degenerate
);

   localparam int CMP_BITS = SUM_BITS + 2;

   logic                       det_neg;
   logic signed [SUM_BITS-1:0] det_abs, nu_n, nv_n;

   // stage 4
   logic signed [CMP_BITS-1:0] det_ff, three_det_ff, four_nu_ff, four_nv_ff;
   logic                       zero_ff;
   // stage 5
   logic [1:0]                 row_ff, col_ff;
   logic                       degen_ff;

   assign det_neg = det[SUM_BITS-1];
   assign det_abs = det_neg ? -det : det;
   assign nu_n    = det_neg ? -nu  : nu;
   assign nv_n    = det_neg ? -nv  : nv;

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         det_ff       <= CMP_BITS'(det_abs);
         three_det_ff <= CMP_BITS'(det_abs) + (CMP_BITS'(det_abs) <<< 1);
         four_nu_ff   <= {nu_n, 2'b00};
         four_nv_ff   <= {nv_n, 2'b00};
         zero_ff      <= (det == '0);
      end
      if (stage_en[1]) begin
         degen_ff <= zero_ff;
         if (zero_ff) begin
            row_ff <= CELL_LO;
            col_ff <= CELL_LO;
         end else begin
            row_ff <= cell_of(four_nv_ff < det_ff, four_nv_ff < three_det_ff);
            col_ff <= cell_of(four_nu_ff < det_ff, four_nu_ff < three_det_ff);
         end
      end
   end

   assign grid_row   = row_ff;
   assign grid_col   = col_ff;
   assign degenerate = degen_ff;

endmodule

// ----- tb/grid_cell_from_parallelogram_unit_tb.sv -----
// Testbench for the grid cell unit: directed and random points, checked against a predictor
`timescale 1ns / 1ps

module grid_cell_from_parallelogram_unit_tb import gcp_pkg::*;;

   localparam int COORD_BITS   = COORD_BITS_DEF;
   localparam int ID_BITS      = ID_BITS_DEF;
   localparam int REQ_BITS     = ((2 * COORD_BITS + ID_BITS + 7) / 8) * 8;
   localparam int RSP_BITS     = ((ID_BITS + 4 + 7) / 8) * 8;
   localparam int COORD_MAX    = (1 << COORD_BITS) - 1;
   localparam int LIMIT_CYCLES = 200000;
   localparam int NUM_PHASES   = 9;
   localparam int PHASE_ITEMS  = 150;
   localparam int NUM_DIRECTED = 25;
   localparam int NUM_SETUPS   = 7;

   // register indexes past the map; writes there must change nothing
   localparam logic [REG_IDX_BITS-1:0] REG_SPARE_LO = REG_IDX_BITS'(NUM_REGS);
   localparam logic [REG_IDX_BITS-1:0] REG_SPARE_HI = REG_IDX_BITS'(NUM_REGS + 1);

   // corner set kinds of the random phases
   typedef enum int {
      CORNERS_ANY, CORNERS_BOX, CORNERS_MIRRORED, CORNERS_COLLINEAR
   } corner_kind_type;

   // one placed point, as the rsp side carries it
   typedef struct {
      logic [ID_BITS-1:0] id;
      logic [1:0]         row;
      logic [1:0]         col;
      logic               deg;
   } placement_type;

   // one directed item; setup selects the corner set it runs under
   typedef struct {
      int         setup;
      int         px;
      int         py;
      int         pid;
      bit         typed;
      logic [1:0] row;
      logic [1:0] col;
      bit         deg;
   } point_row_type;

   logic                     clock;
   logic                     reset;
   logic                     req_tvalid;
   logic                     req_tready;
   // point_x, point_y, point_id (lowest bit first), zero padded
   logic [REQ_BITS-1:0]      req_tdata;
   logic                     rsp_tvalid;
   logic                     rsp_tready;
   // result_id, grid_row, grid_col (lowest bit first), zero padded
   logic [RSP_BITS-1:0]      rsp_tdata;
   // degenerate
   logic                     rsp_tuser;
   logic                     csr_psel;
   logic                     csr_penable;
   logic                     csr_pwrite;
   logic [CSR_ADDR_BITS-1:0] csr_paddr;
   logic [CSR_DATA_BITS-1:0] csr_pwdata;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic                     csr_pready;

   grid_cell_from_parallelogram_unit #(
      .COORD_BITS(COORD_BITS),
      .ID_BITS   (ID_BITS)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready)
   );

   // our copy of the six corner registers
   logic [COORD_BITS-1:0] corner [NUM_REGS];

   placement_type pending [$];   // placements still owed by the block, oldest first
   int            errors;
   int            cycles;
   int            idle_pct;      // chance per cycle, in percent, that a side idles
   bit            typed_on;      // item on req carries a hand-typed placement
   placement_type typed_res;

   // Directed items. Setup 0 is the reset state (all corners 0, det is 0).
   // Setup 1: axis square TL(100,100) TR(500,100) BL(100,500), so u = (x-100)/400.
   // Setup 2: the same square mirrored left to right, negative det.
   // Setups 3/4: corners at the coordinate extremes. Setup 5: collinear corners.
   // Setup 6: skewed shape, checked by the predictor only.
   int setup_corners [NUM_SETUPS][6] = '{
      '{0, 0, 0, 0, 0, 0},
      '{100, 100, 500, 100, 100, 500},
      '{500, 100, 100, 100, 500, 500},
      '{0, 0, COORD_MAX, 0, 0, COORD_MAX},
      '{COORD_MAX, COORD_MAX, 0, COORD_MAX, COORD_MAX, 0},
      '{10, 10, 20, 20, 30, 30},
      '{1000, 1000, 3000, 1500, 500, 3000}
   };

   point_row_type directed_rows [NUM_DIRECTED] = '{
      // corners all zero: every item flagged, id still passes
      '{0, 0, 0, 8'h00, 1, CELL_LO, CELL_LO, 1},
      '{0, COORD_MAX, COORD_MAX, 8'hFF, 1, CELL_LO, CELL_LO, 1},
      // square: corners, center, both sides of the 1/4 and 3/4 marks
      '{1, 100, 100, 8'h01, 1, CELL_LO, CELL_LO, 0},
      '{1, 500, 500, 8'h02, 1, CELL_HI, CELL_HI, 0},
      '{1, 300, 300, 8'h03, 1, CELL_MID, CELL_MID, 0},
      '{1, 199, 100, 8'h04, 1, CELL_LO, CELL_LO, 0},
      '{1, 200, 100, 8'h05, 1, CELL_LO, CELL_MID, 0},
      '{1, 399, 399, 8'h06, 1, CELL_MID, CELL_MID, 0},
      '{1, 400, 400, 8'h07, 1, CELL_HI, CELL_HI, 0},
      // outside the shape: clamped to the nearest edge cell
      '{1, 0, 0, 8'h08, 1, CELL_LO, CELL_LO, 0},
      '{1, COORD_MAX, COORD_MAX, 8'h09, 1, CELL_HI, CELL_HI, 0},
      '{1, COORD_MAX, 0, 8'h0A, 1, CELL_LO, CELL_HI, 0},
      '{1, 0, COORD_MAX, 8'h0B, 1, CELL_HI, CELL_LO, 0},
      // mirrored: sign of det normalized away
      '{2, 100, 100, 8'h0C, 1, CELL_LO, CELL_HI, 0},
      '{2, 500, 500, 8'h0D, 1, CELL_HI, CELL_LO, 0},
      '{3, 0, 0, 8'h0E, 1, CELL_LO, CELL_LO, 0},
      '{3, COORD_MAX, COORD_MAX, 8'h0F, 1, CELL_HI, CELL_HI, 0},
      '{3, 2048, 2047, 8'h3C, 0, CELL_LO, CELL_LO, 0},
      '{4, COORD_MAX, COORD_MAX, 8'h10, 1, CELL_LO, CELL_LO, 0},
      '{4, 0, 0, 8'hF0, 1, CELL_HI, CELL_HI, 0},
      '{5, 15, 15, 8'h80, 1, CELL_LO, CELL_LO, 1},
      '{5, 4000, 12, 8'h7F, 1, CELL_LO, CELL_LO, 1},
      '{6, 1800, 1700, 8'h11, 0, CELL_LO, CELL_LO, 0},
      '{6, 2500, 2600, 8'h22, 0, CELL_LO, CELL_LO, 0},
      '{6, 700, 2900, 8'h33, 0, CELL_LO, CELL_LO, 0}
   };

   // 20 ns clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT_CYCLES) begin
         $display("Some tests failed");
         $finish;
      end
   end

   task automatic flag_mismatch(input string what);
      errors++;
      if (errors <= 40) $display("MISMATCH at cycle %0d: %s", cycles, what);
   endtask

   // append one owed placement at the tail of the queue
   task automatic owe_result(input placement_type p);
      pending = {pending, p};
   endtask

   // n/den with den > 0: below 1/4 -> low cell, below 3/4 -> middle, else high
   function automatic logic [1:0] grid_index(input longint n, input longint den);
      if (4 * n < den) return CELL_LO;
      if (4 * n < 3 * den) return CELL_MID;
      return CELL_HI;
   endfunction

   // Expected placement of one point under the current corners
   function automatic placement_type place_point(input logic [COORD_BITS-1:0] px,
                                                 input logic [COORD_BITS-1:0] py,
                                                 input logic [ID_BITS-1:0] pid);
      longint        ox, oy, a, b, c, d, det, rx, ry, nu, nv;
      placement_type r;
      ox = corner[REG_TOP_LEFT_X];
      oy = corner[REG_TOP_LEFT_Y];
      a = longint'(corner[REG_TOP_RIGHT_X]) - ox;
      c = longint'(corner[REG_TOP_RIGHT_Y]) - oy;
      b = longint'(corner[REG_BOTTOM_LEFT_X]) - ox;
      d = longint'(corner[REG_BOTTOM_LEFT_Y]) - oy;
      det = a * d - b * c;
      r.id = pid;
      r.row = CELL_LO;
      r.col = CELL_LO;
      r.deg = 1'b0;
      if (det == 0) begin
         r.deg = 1'b1;   // collinear corners: cell fields forced low
      end else begin
         rx = longint'(px) - ox;
         ry = longint'(py) - oy;
         nu = d * rx - b * ry;
         nv = a * ry - c * rx;
         if (det < 0) begin
            det = -det;
            nu = -nu;
            nv = -nv;
         end
         r.row = grid_index(nv, det);
         r.col = grid_index(nu, det);
      end
      return r;
   endfunction

   // Scoreboard: predict on every accepted point, check every accepted result
   always @(posedge clock) begin
      placement_type want;
      placement_type got;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            if (typed_on) begin
               owe_result(typed_res);
            end else begin
               owe_result(place_point(req_tdata[COORD_BITS-1:0],
                                      req_tdata[2*COORD_BITS-1:COORD_BITS],
                                      req_tdata[2*COORD_BITS +: ID_BITS]));
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            got.id = rsp_tdata[ID_BITS-1:0];
            got.row = rsp_tdata[ID_BITS +: 2];
            got.col = rsp_tdata[ID_BITS+2 +: 2];
            got.deg = rsp_tuser;
            if (pending.size() == 0) begin
               flag_mismatch($sformatf("unexpected result id=%0d", got.id));
            end else begin
               want = pending.pop_front();
               if (got.id !== want.id)
                  flag_mismatch($sformatf("id %0d, want %0d", got.id, want.id));
               if (got.row !== want.row)
                  flag_mismatch($sformatf("row %0d, want %0d (id %0d)", got.row, want.row,
                                          want.id));
               if (got.col !== want.col)
                  flag_mismatch($sformatf("col %0d, want %0d (id %0d)", got.col, want.col,
                                          want.id));
               if (got.deg !== want.deg)
                  flag_mismatch($sformatf("degenerate %0b, want %0b (id %0d)", got.deg,
                                          want.deg, want.id));
            end
         end
      end
   end

   // result side backpressure
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= idle_pct);
   end

   task automatic wait_drained();
      while (pending.size() != 0) @(posedge clock);
   endtask

   // APB write; junk above the field width must be dropped
   task automatic csr_write(input logic [REG_IDX_BITS-1:0] idx, input int val);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= {(CSR_DATA_BITS - COORD_BITS)'($urandom), COORD_BITS'(val)};
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (idx < NUM_REGS) corner[idx] = COORD_BITS'(val);
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   task automatic csr_read(input logic [REG_IDX_BITS-1:0] idx);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= {idx, 2'b00};
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (csr_prdata !== CSR_DATA_BITS'(corner[idx]))
         flag_mismatch($sformatf("register %0d reads %0h, want %0h", idx, csr_prdata,
                                 corner[idx]));
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // all six corners, a poke at the unmapped slots, then read back
   task automatic apply_corners(input int tl_x, input int tl_y, input int tr_x,
                                input int tr_y, input int bl_x, input int bl_y);
      csr_write(REG_TOP_LEFT_X, tl_x);
      csr_write(REG_TOP_LEFT_Y, tl_y);
      csr_write(REG_TOP_RIGHT_X, tr_x);
      csr_write(REG_TOP_RIGHT_Y, tr_y);
      csr_write(REG_BOTTOM_LEFT_X, bl_x);
      csr_write(REG_BOTTOM_LEFT_Y, bl_y);
      csr_write(REG_SPARE_LO, $urandom);
      csr_write(REG_SPARE_HI, $urandom);
      csr_read(REG_TOP_LEFT_X);
      csr_read(REG_TOP_LEFT_Y);
      csr_read(REG_TOP_RIGHT_X);
      csr_read(REG_TOP_RIGHT_Y);
      csr_read(REG_BOTTOM_LEFT_X);
      csr_read(REG_BOTTOM_LEFT_Y);
   endtask

   // Present one point and hold it until taken. tvalid stays high when no
   // gap is drawn, so back-to-back items never toggle it within a step.
   task automatic send_point(input int px, input int py, input int pid, input bit typed,
                             input placement_type want);
      @(negedge clock);
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      typed_on = typed;
      typed_res = want;
      req_tvalid <= 1'b1;
      req_tdata <= REQ_BITS'({ID_BITS'(pid), COORD_BITS'(py), COORD_BITS'(px)});
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   function automatic int clamp_coord(input int v);
      if (v < 0) return 0;
      if (v > COORD_MAX) return COORD_MAX;
      return v;
   endfunction

   // random corner set of the given kind
   task automatic random_corners(input corner_kind_type kind);
      int x0, y0, w, h, s1, s2, dx, dy;
      case (kind)
         CORNERS_ANY: begin
            apply_corners($urandom_range(COORD_MAX), $urandom_range(COORD_MAX),
                          $urandom_range(COORD_MAX), $urandom_range(COORD_MAX),
                          $urandom_range(COORD_MAX), $urandom_range(COORD_MAX));
         end
         CORNERS_BOX, CORNERS_MIRRORED: begin
            x0 = $urandom_range(2047);
            y0 = $urandom_range(2047);
            w = $urandom_range(1, 2047);
            h = $urandom_range(1, 2047);
            s1 = $urandom_range(300) - 150;
            s2 = $urandom_range(300) - 150;
            if (kind == CORNERS_BOX) begin
               apply_corners(x0, y0, x0 + w, clamp_coord(y0 + s1),
                             clamp_coord(x0 + s2), y0 + h);
            end else begin
               // reflect in x: det changes sign
               apply_corners(COORD_MAX - x0, y0, COORD_MAX - (x0 + w), clamp_coord(y0 + s1),
                             COORD_MAX - clamp_coord(x0 + s2), y0 + h);
            end
         end
         default: begin
            x0 = $urandom_range(1000);
            y0 = $urandom_range(1000);
            dx = $urandom_range(1000);
            dy = $urandom_range(1000);
            apply_corners(x0, y0, x0 + dx, y0 + dy, x0 + 2 * dx, y0 + 2 * dy);
         end
      endcase
   endtask

   // Mostly points spread over the shape and a margin around it
   // (s, t in [-0.2, 1.2] of the edges), the rest anywhere.
   task automatic random_point(output int px, output int py);
      int a, b, c, d, s, t;
      if ($urandom_range(99) < 20) begin
         px = $urandom_range(COORD_MAX);
         py = $urandom_range(COORD_MAX);
      end else begin
         a = int'(corner[REG_TOP_RIGHT_X]) - int'(corner[REG_TOP_LEFT_X]);
         c = int'(corner[REG_TOP_RIGHT_Y]) - int'(corner[REG_TOP_LEFT_Y]);
         b = int'(corner[REG_BOTTOM_LEFT_X]) - int'(corner[REG_TOP_LEFT_X]);
         d = int'(corner[REG_BOTTOM_LEFT_Y]) - int'(corner[REG_TOP_LEFT_Y]);
         s = int'($urandom_range(700)) - 100;
         t = int'($urandom_range(700)) - 100;
         px = clamp_coord(int'(corner[REG_TOP_LEFT_X]) + (a * s) / 500 + (b * t) / 500);
         py = clamp_coord(int'(corner[REG_TOP_LEFT_Y]) + (c * s) / 500 + (d * t) / 500);
      end
   endtask

   initial begin
      corner_kind_type phase_kind [NUM_PHASES];
      placement_type   no_typed;
      int              cur_setup;
      int              px, py;

      clock = 1'b0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      rsp_tready = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      typed_on = 1'b0;
      typed_res = '{default: '0};
      no_typed = '{default: '0};
      errors = 0;
      cycles = 0;
      idle_pct = 33;
      for (int i = 0; i < NUM_REGS; i++) corner[i] = '0;

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reset values read back as zero
      for (int i = 0; i < NUM_REGS; i++) csr_read(REG_IDX_BITS'(i));

      // directed part; corners change only with the pipeline empty
      cur_setup = 0;
      foreach (directed_rows[i]) begin
         if (directed_rows[i].setup != cur_setup) begin
            cur_setup = directed_rows[i].setup;
            @(negedge clock);
            req_tvalid <= 1'b0;
            wait_drained();
            apply_corners(setup_corners[cur_setup][0], setup_corners[cur_setup][1],
                          setup_corners[cur_setup][2], setup_corners[cur_setup][3],
                          setup_corners[cur_setup][4], setup_corners[cur_setup][5]);
         end
         send_point(directed_rows[i].px, directed_rows[i].py, directed_rows[i].pid,
                    directed_rows[i].typed,
                    '{id: ID_BITS'(directed_rows[i].pid), row: directed_rows[i].row,
                      col: directed_rows[i].col, deg: directed_rows[i].deg});
      end

      // random part: one corner set per phase
      phase_kind = '{CORNERS_BOX, CORNERS_ANY, CORNERS_MIRRORED, CORNERS_COLLINEAR,
                     CORNERS_BOX, CORNERS_ANY, CORNERS_MIRRORED, CORNERS_BOX, CORNERS_ANY};
      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         wait_drained();
         random_corners(phase_kind[ph]);
         idle_pct = (ph == 4) ? 0 : 33;   // one phase runs at full rate on both sides
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (ph == 2 && n == PHASE_ITEMS / 2) begin
               // hold off until the pipeline has emptied, then resume
               @(negedge clock);
               req_tvalid <= 1'b0;
               wait_drained();
            end
            random_point(px, py);
            send_point(px, py, $urandom_range((1 << ID_BITS) - 1), 1'b0, no_typed);
         end
      end
      idle_pct = 33;

      @(negedge clock);
      req_tvalid <= 1'b0;
      wait_drained();
      repeat (4 * NUM_STAGES) @(posedge clock);
      if (pending.size() != 0)
         flag_mismatch($sformatf("%0d results never arrived", pending.size()));

      if (errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
